### rtl/pts_pkg.sv
// Shared definitions for the periodic timer slot table.
// Request and status codes, head control/event structs, saturation helper.
// No dependencies.
`default_nettype none

package pts_pkg;

	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_INSERT  = 3'd1;
	localparam logic [2:0] REQ_REMOVE  = 3'd2;
	localparam logic [2:0] REQ_SETIVL  = 3'd3;
	localparam logic [2:0] REQ_SETSUSP = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FIRED    = 3'd1;
	localparam logic [2:0] ST_NONE     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_BADIVL   = 3'd5;

	typedef struct packed {
		logic [2:0]  req;
		logic        pass2;
		logic        apply;
		logic [15:0] delta;
		logic [30:0] ival;
		logic [31:0] reps;
		logic        susp;
	} head_ctrl_t;

	typedef struct packed {
		logic match;
		logic empty;
		logic fire;
		logic fin;
	} head_evt_t;

	// clamp a 34-bit two's complement value to the signed 32-bit range
	function automatic logic [31:0] sat34(input logic [33:0] v);
		logic [31:0] r;
		if (v[33] && (v[32:31] != 2'b11)) begin
			r = 32'h8000_0000;
		end else if (!v[33] && (v[32:31] != 2'b00)) begin
			r = 32'h7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/pts_cell.sv
// One timer slot register of the rotating slot chain.
// Loads its neighbour's record when enabled. Uses no package items.
`default_nettype none

module pts_cell #(
	parameter int ID_BITS = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 d_used,
	input  wire  [ID_BITS-1:0]  d_owner,
	input  wire  [31:0]         d_rem,
	input  wire  [30:0]         d_ival,
	input  wire  [31:0]         d_reps,
	input  wire                 d_susp,
	output logic                used,
	output logic [ID_BITS-1:0]  owner,
	output logic [31:0]         rem,
	output logic [30:0]         ival,
	output logic [31:0]         reps,
	output logic                susp
);

	logic               used_q;
	logic [ID_BITS-1:0] owner_q;
	logic [31:0]        rem_q;
	logic [30:0]        ival_q;
	logic [31:0]        reps_q;
	logic               susp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			owner_q <= '0;
			rem_q   <= '0;
			ival_q  <= '0;
			reps_q  <= '0;
			susp_q  <= 1'b0;
		end else if (en) begin
			used_q  <= d_used;
			owner_q <= d_owner;
			rem_q   <= d_rem;
			ival_q  <= d_ival;
			reps_q  <= d_reps;
			susp_q  <= d_susp;
		end
	end

	assign used  = used_q;
	assign owner = owner_q;
	assign rem   = rem_q;
	assign ival  = ival_q;
	assign reps  = reps_q;
	assign susp  = susp_q;

endmodule

`default_nettype wire

### rtl/pts_head.sv
// Update unit at the head of the slot chain: applies the current request
// to the slot record passing by. Depends on pts_pkg.
`default_nettype none

module pts_head #(
	parameter int ID_BITS = 8
) (
	input  pts_pkg::head_ctrl_t ctrl,
	input  wire  [ID_BITS-1:0]  id,
	input  wire                 in_used,
	input  wire  [ID_BITS-1:0]  in_owner,
	input  wire  [31:0]         in_rem,
	input  wire  [30:0]         in_ival,
	input  wire  [31:0]         in_reps,
	input  wire                 in_susp,
	output logic                out_used,
	output logic [ID_BITS-1:0]  out_owner,
	output logic [31:0]         out_rem,
	output logic [30:0]         out_ival,
	output logic [31:0]         out_reps,
	output logic                out_susp,
	output pts_pkg::head_evt_t  evt
);

	import pts_pkg::*;

	logic [33:0] rem_x;
	logic [31:0] tick_rem;
	logic [31:0] ivl_rem;
	logic        tick_expired;
	logic        match;

	assign rem_x        = {{2{in_rem[31]}}, in_rem};
	assign tick_rem     = sat34(rem_x - {18'b0, ctrl.delta});
	assign ivl_rem      = sat34(rem_x + {3'b0, ctrl.ival} - {3'b0, in_ival});
	assign tick_expired = tick_rem[31] || (tick_rem == 32'd0);
	assign match        = in_used && (in_owner == id);

	always_comb begin
		out_used  = in_used;
		out_owner = in_owner;
		out_rem   = in_rem;
		out_ival  = in_ival;
		out_reps  = in_reps;
		out_susp  = in_susp;
		evt       = '0;
		evt.match = match;
		evt.empty = !in_used;
		unique case (ctrl.req)
			REQ_TICK: begin
				if (in_used) begin
					if (!tick_expired) begin
						out_rem = tick_rem;
					end else begin
						out_rem = {1'b0, in_ival};
						if (!in_susp) begin
							evt.fire = 1'b1;
							if (in_reps != 32'd0) begin
								out_reps = in_reps - 32'd1;
								if (in_reps == 32'd1) begin
									evt.fin   = 1'b1;
									out_used  = 1'b0;
									out_owner = '0;
									out_rem   = '0;
									out_ival  = '0;
									out_reps  = '0;
									out_susp  = 1'b0;
								end
							end
						end
					end
				end
			end
			REQ_INSERT: begin
				if (ctrl.pass2 && ctrl.apply) begin
					out_used  = 1'b1;
					out_owner = id;
					out_ival  = ctrl.ival;
					out_rem   = {1'b0, ctrl.ival};
					out_reps  = ctrl.reps;
					out_susp  = 1'b0;
				end
			end
			REQ_REMOVE: begin
				if (match) begin
					out_used  = 1'b0;
					out_owner = '0;
					out_rem   = '0;
					out_ival  = '0;
					out_reps  = '0;
					out_susp  = 1'b0;
				end
			end
			REQ_SETIVL: begin
				if (match && ctrl.apply) begin
					out_rem  = ivl_rem;
					out_ival = ctrl.ival;
				end
			end
			REQ_SETSUSP: begin
				if (match && ctrl.apply) begin
					out_susp = ctrl.susp;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/periodic_timer_slot_table.sv
// Periodic timer slot table, top level: request sequencer, slot chain, result register.
// Depends on pts_pkg, pts_cell, pts_head.
//
// The SLOT_COUNT slots sit in a ring of cells that rotates one slot per cycle past a
// single update unit while no fired result is held up by a stalled output, so each
// accepted request that scans walks the table in slot order. A request is taken only
// while the sequencer is idle. Tick, remove, set interval and set suspend take a
// lap of the ring before the final result is offered; insert of a new id takes a
// search lap, then a write lap. Rejected intervals and unknown requests skip the laps
// and go straight to the final state. A final result waits in that state while the
// output is stalled. The next request is taken in the cycle after the final result is
// loaded. Results leave through a one-entry output register, so the next request can
// be taken while the last result still waits.
`default_nettype none

module periodic_timer_slot_table #(
	parameter int SLOT_COUNT = 16,
	parameter int ID_BITS    = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// [2:0] req_type, [10:3] routine_id, [26:11] delta_ms, [58:27] interval_ms,
	// [90:59] repeat_count, [91] suspend, [95:92] zero
	input  wire  [95:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// [2:0] status, [6:3] slot, [14:7] owner_id, [15] finished
	output logic [15:0] m_tdata,
	output logic        m_tlast
);

	import pts_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(SLOT_COUNT - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_WRITE = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0]         state_q;
	logic [2:0]         req_q;
	logic [ID_BITS-1:0] id_q;
	logic [15:0]        delta_q;
	logic [30:0]        ival_q;
	logic [31:0]        reps_q;
	logic               susp_q;
	logic [IDX_W-1:0]   pos_q;
	logic               found_q;
	logic [IDX_W-1:0]   first_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_q;
	logic               pend_valid_q;
	logic [3:0]         pend_slot_q;
	logic [7:0]         pend_owner_q;
	logic               pend_fin_q;
	logic [2:0]         res_status_q;
	logic [3:0]         res_slot_q;
	logic [7:0]         res_owner_q;
	logic               res_fin_q;
	logic               out_valid_q;
	logic [2:0]         out_status_q;
	logic [3:0]         out_slot_q;
	logic [7:0]         out_owner_q;
	logic               out_fin_q;
	logic               out_last_q;

	logic               c_used  [SLOT_COUNT];
	logic [ID_BITS-1:0] c_owner [SLOT_COUNT];
	logic [31:0]        c_rem   [SLOT_COUNT];
	logic [30:0]        c_ival  [SLOT_COUNT];
	logic [31:0]        c_reps  [SLOT_COUNT];
	logic               c_susp  [SLOT_COUNT];

	logic               h_used;
	logic [ID_BITS-1:0] h_owner;
	logic [31:0]        h_rem;
	logic [30:0]        h_ival;
	logic [31:0]        h_reps;
	logic               h_susp;

	head_ctrl_t         ctrl;
	head_evt_t          evt;
	logic               out_busy;
	logic               step;
	logic               pass_end;
	logic [IDX_W-1:0]   pos_next;
	logic               found_now;
	logic [IDX_W-1:0]   first_now;
	logic               free_now;
	logic [IDX_W-1:0]   free_idx_now;
	logic [2:0]         in_req;
	logic [7:0]         in_id;

	assign in_req = s_tdata[2:0];
	assign in_id  = s_tdata[10:3];

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_fin_q, out_owner_q, out_slot_q, out_status_q};
	assign m_tlast  = out_last_q;

	assign out_busy = out_valid_q && !m_tready;
	assign step     = ((state_q == S_SCAN) && !(evt.fire && pend_valid_q && out_busy))
	                  || (state_q == S_WRITE);
	assign pass_end = (pos_q == LAST_POS);
	assign pos_next = pass_end ? '0 : pos_q + 1'b1;

	assign found_now    = found_q || evt.match;
	assign first_now    = found_q ? first_q : pos_q;
	assign free_now     = free_found_q || evt.empty;
	assign free_idx_now = free_found_q ? free_q : pos_q;

	always_comb begin
		ctrl       = '0;
		ctrl.req   = req_q;
		ctrl.pass2 = (state_q == S_WRITE);
		ctrl.apply = (state_q == S_WRITE) ? (pos_q == free_q) : !found_q;
		ctrl.delta = delta_q;
		ctrl.ival  = ival_q;
		ctrl.reps  = reps_q;
		ctrl.susp  = susp_q;
	end

	pts_head #(
		.ID_BITS (ID_BITS)
	) u_head (
		.ctrl      (ctrl),
		.id        (id_q),
		.in_used   (c_used[0]),
		.in_owner  (c_owner[0]),
		.in_rem    (c_rem[0]),
		.in_ival   (c_ival[0]),
		.in_reps   (c_reps[0]),
		.in_susp   (c_susp[0]),
		.out_used  (h_used),
		.out_owner (h_owner),
		.out_rem   (h_rem),
		.out_ival  (h_ival),
		.out_reps  (h_reps),
		.out_susp  (h_susp),
		.evt       (evt)
	);

	// cell i takes cell i+1; the last cell takes the updated head record
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		if (i == SLOT_COUNT - 1) begin : g_tail
			pts_cell #(
				.ID_BITS (ID_BITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (step),
				.d_used  (h_used),
				.d_owner (h_owner),
				.d_rem   (h_rem),
				.d_ival  (h_ival),
				.d_reps  (h_reps),
				.d_susp  (h_susp),
				.used    (c_used[i]),
				.owner   (c_owner[i]),
				.rem     (c_rem[i]),
				.ival    (c_ival[i]),
				.reps    (c_reps[i]),
				.susp    (c_susp[i])
			);
		end else begin : g_mid
			pts_cell #(
				.ID_BITS (ID_BITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (step),
				.d_used  (c_used[i+1]),
				.d_owner (c_owner[i+1]),
				.d_rem   (c_rem[i+1]),
				.d_ival  (c_ival[i+1]),
				.d_reps  (c_reps[i+1]),
				.d_susp  (c_susp[i+1]),
				.used    (c_used[i]),
				.owner   (c_owner[i]),
				.rem     (c_rem[i]),
				.ival    (c_ival[i]),
				.reps    (c_reps[i]),
				.susp    (c_susp[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= REQ_TICK;
			id_q         <= '0;
			delta_q      <= '0;
			ival_q       <= '0;
			reps_q       <= '0;
			susp_q       <= 1'b0;
			pos_q        <= '0;
			found_q      <= 1'b0;
			first_q      <= '0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_slot_q  <= '0;
			pend_owner_q <= '0;
			pend_fin_q   <= 1'b0;
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			res_owner_q  <= '0;
			res_fin_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_slot_q   <= '0;
			out_owner_q  <= '0;
			out_fin_q    <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						req_q        <= in_req;
						id_q         <= ID_BITS'(in_id);
						delta_q      <= s_tdata[26:11];
						ival_q       <= s_tdata[57:27];
						reps_q       <= s_tdata[90:59];
						susp_q       <= s_tdata[91];
						pos_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						pend_valid_q <= 1'b0;
						res_fin_q    <= 1'b0;
						res_slot_q   <= '0;
						if (((in_req == REQ_INSERT) || (in_req == REQ_SETIVL)) && s_tdata[58]) begin
							res_status_q <= ST_BADIVL;
							res_owner_q  <= 8'(ID_BITS'(in_id));
							state_q      <= S_FIN;
						end else if ((in_req != REQ_TICK) && (in_req != REQ_INSERT)
						             && (in_req != REQ_REMOVE) && (in_req != REQ_SETIVL)
						             && (in_req != REQ_SETSUSP)) begin
							res_status_q <= ST_OK;
							res_owner_q  <= '0;
							state_q      <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (step) begin
						pos_q <= pos_next;
						if (evt.fire) begin
							if (pend_valid_q) begin
								out_valid_q  <= 1'b1;
								out_status_q <= ST_FIRED;
								out_slot_q   <= pend_slot_q;
								out_owner_q  <= pend_owner_q;
								out_fin_q    <= pend_fin_q;
								out_last_q   <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_slot_q  <= 4'(pos_q);
							pend_owner_q <= 8'(c_owner[0]);
							pend_fin_q   <= evt.fin;
						end
						if (evt.match && !found_q) begin
							found_q <= 1'b1;
							first_q <= pos_q;
						end
						if (evt.empty && !free_found_q) begin
							free_found_q <= 1'b1;
							free_q       <= pos_q;
						end
						if (pass_end) begin
							state_q     <= S_FIN;
							res_fin_q   <= 1'b0;
							res_owner_q <= 8'(id_q);
							res_slot_q  <= '0;
							if (req_q == REQ_TICK) begin
								pend_valid_q <= 1'b0;
								if (evt.fire) begin
									res_status_q <= ST_FIRED;
									res_slot_q   <= 4'(pos_q);
									res_owner_q  <= 8'(c_owner[0]);
									res_fin_q    <= evt.fin;
								end else if (pend_valid_q) begin
									res_status_q <= ST_FIRED;
									res_slot_q   <= pend_slot_q;
									res_owner_q  <= pend_owner_q;
									res_fin_q    <= pend_fin_q;
								end else begin
									res_status_q <= ST_NONE;
									res_owner_q  <= '0;
								end
							end else if (found_now) begin
								res_status_q <= ST_OK;
								res_slot_q   <= 4'(first_now);
							end else if (req_q != REQ_INSERT) begin
								res_status_q <= ST_NOTFOUND;
							end else if (free_now) begin
								res_status_q <= ST_OK;
								res_slot_q   <= 4'(free_idx_now);
								free_q       <= free_idx_now;
								free_found_q <= 1'b1;
								state_q      <= S_WRITE;
							end else begin
								res_status_q <= ST_FULL;
							end
						end
					end
				end
				S_WRITE: begin
					pos_q <= pos_next;
					if (pass_end) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_busy) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						out_owner_q  <= res_owner_q;
						out_fin_q    <= res_fin_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("fired result pending while idle");

	a_ring_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) || (state_q == S_FIN)) |-> (pos_q == '0))
		else $error("slot ring not aligned outside a lap");

	a_write_has_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> (free_found_q && !found_q && (req_q == REQ_INSERT)))
		else $error("write lap without a free target");

	a_no_push_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(step && evt.fire && pend_valid_q) |-> !out_busy)
		else $error("fired result pushed into a stalled output");

endmodule

`default_nettype wire
